FILE: src/slcd_pkg.sv
// ----------------------------------------------------------------------------
// slcd_pkg
// Types and constants shared by the register-log command decoder.
// ----------------------------------------------------------------------------
package slcd_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned DEV_W    = 6;
  localparam int unsigned ACC_W    = 28;
  localparam int unsigned COUNT_W  = 29;
  localparam int unsigned SYNC_W   = 32;
  localparam int unsigned PROD_W   = SYNC_W + COUNT_W;
  localparam int unsigned WAIT_W   = 45;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned CFG_IDX_W = 8;

  // command bytes
  localparam logic [BYTE_W-1:0] CMD_SYNC   = 8'hFF;
  localparam logic [BYTE_W-1:0] CMD_SYNC_N = 8'hFE;
  localparam logic [BYTE_W-1:0] CMD_LOOP   = 8'hFD;

  // rounding constant for 16.16 to integer
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32'h0000_8000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SAMPLES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_ENABLED = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOPS_WANTED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_COUNT = 8'd3;

  // configuration reset values
  localparam logic [SYNC_W-1:0] SYNC_SAMPLES_RST = 32'd36350198;
  localparam logic [7:0]        LOOPS_WANTED_RST = 8'd1;
  localparam logic [3:0]        DEVICE_COUNT_RST = 4'd1;

  typedef enum logic [1:0] {
    EV_WRITE   = 2'd0,
    EV_WAIT    = 2'd1,
    EV_RESTART = 2'd2,
    EV_END     = 2'd3
  } slcd_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ADDR  = 2'd1,
    PH_DATA  = 2'd2,
    PH_COUNT = 2'd3
  } slcd_phase_t;

  typedef struct packed {
    logic [SYNC_W-1:0] sync_samples;
    logic              loop_enabled;
    logic [7:0]        loops_wanted;
    logic [3:0]        device_count;
  } slcd_cfg_t;

  // up to two results per byte: a primary event and a trailing end
  typedef struct packed {
    logic               has_primary;
    slcd_kind_t         kind;
    logic [2:0]         device;
    logic               high_bank;
    logic [BYTE_W-1:0]  reg_address;
    logic [BYTE_W-1:0]  reg_data;
    logic [COUNT_W-1:0] sync_count;
    logic               has_end;
  } slcd_event_t;

endpackage

FILE: src/slcd_channels.sv
// ----------------------------------------------------------------------------
// slcd channels
// Valid/ready channels for the byte stream, the event output and the
// configuration writes.
// ----------------------------------------------------------------------------
interface slcd_stream_if;
  import slcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] stream_byte;
  logic              is_last;

  modport source (output valid, output stream_byte, output is_last, input ready);
  modport sink   (input valid, input stream_byte, input is_last, output ready);
endinterface

interface slcd_event_if;
  import slcd_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [2:0]        device;
  logic              high_bank;
  logic [BYTE_W-1:0] reg_address;
  logic [BYTE_W-1:0] reg_data;
  logic [WAIT_W-1:0] wait_samples;
  logic              last_of_run;

  modport source (output valid, output event_kind, output device, output high_bank,
                  output reg_address, output reg_data, output wait_samples,
                  output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input device, input high_bank,
                  input reg_address, input reg_data, input wait_samples,
                  input last_of_run, output ready);
endinterface

interface slcd_cfg_if;
  import slcd_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [SYNC_W-1:0]    write_data;

  modport source (output valid, output reg_index, output write_data, input ready);
  modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

FILE: src/slcd_cfg_regs.sv
// ----------------------------------------------------------------------------
// slcd_cfg_regs
// Configuration register file; writes are always accepted.
// ----------------------------------------------------------------------------
module slcd_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  slcd_cfg_if.sink          cfg,
  output slcd_pkg::slcd_cfg_t regs
);
  import slcd_pkg::*;

  assign cfg.ready = 1'b1;

  // register writes by index, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_samples <= SYNC_SAMPLES_RST;
      regs.loop_enabled <= 1'b0;
      regs.loops_wanted <= LOOPS_WANTED_RST;
      regs.device_count <= DEVICE_COUNT_RST;
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        CFG_SYNC_SAMPLES: regs.sync_samples <= cfg.write_data;
        CFG_LOOP_ENABLED: regs.loop_enabled <= cfg.write_data[0];
        CFG_LOOPS_WANTED: regs.loops_wanted <= cfg.write_data[7:0];
        CFG_DEVICE_COUNT: regs.device_count <= cfg.write_data[3:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: src/slcd_decoder.sv
// ----------------------------------------------------------------------------
// slcd_decoder
// Command parser: holds the parse state and turns each accepted byte into
// at most one primary event plus an optional end event.
// ----------------------------------------------------------------------------
module slcd_decoder #(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            stream_byte,
  input  logic                  is_last,
  input  slcd_pkg::slcd_cfg_t   regs,
  output slcd_pkg::slcd_event_t evt,
  output logic                  evt_any
);
  import slcd_pkg::*;

  localparam logic [DEV_W:0] DEV_LIMIT = (DEV_W+1)'(MAX_DEVICES);

  slcd_phase_t       phase, phase_next;
  logic [DEV_W-1:0]  pending_device, pending_device_next;
  logic              pending_bank, pending_bank_next;
  logic [BYTE_W-1:0] pending_address, pending_address_next;
  logic [ACC_W-1:0]  count_acc, count_acc_next;
  logic [1:0]        count_shift, count_shift_next;
  logic [7:0]        passes_done, passes_done_next;
  logic              finished, finished_next;

  logic [ACC_W-1:0]  acc_merged;
  logic              end_now;
  logic              dev_ok;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      pending_device  <= '0;
      pending_bank    <= 1'b0;
      pending_address <= '0;
      count_acc       <= '0;
      count_shift     <= '0;
      passes_done     <= '0;
      finished        <= 1'b0;
    end else if (take) begin
      phase           <= phase_next;
      pending_device  <= pending_device_next;
      pending_bank    <= pending_bank_next;
      pending_address <= pending_address_next;
      count_acc       <= count_acc_next;
      count_shift     <= count_shift_next;
      passes_done     <= passes_done_next;
      finished        <= finished_next;
    end
  end

  // merge the next 7-bit count group at its position
  always_comb begin
    case (count_shift)
      2'd0:    acc_merged = count_acc | ACC_W'(stream_byte[6:0]);
      2'd1:    acc_merged = count_acc | (ACC_W'(stream_byte[6:0]) << 7);
      2'd2:    acc_merged = count_acc | (ACC_W'(stream_byte[6:0]) << 14);
      default: acc_merged = count_acc | (ACC_W'(stream_byte[6:0]) << 21);
    endcase
  end

  assign dev_ok = ({1'b0, pending_device} < {3'b000, regs.device_count}) &&
                  ({1'b0, pending_device} < DEV_LIMIT);

  // byte decode and next state
  always_comb begin
    phase_next           = phase;
    pending_device_next  = pending_device;
    pending_bank_next    = pending_bank;
    pending_address_next = pending_address;
    count_acc_next       = count_acc;
    count_shift_next     = count_shift;
    passes_done_next     = passes_done;
    finished_next        = finished;
    end_now              = is_last;

    evt             = '0;
    evt.kind        = EV_WRITE;
    evt.device      = pending_device[2:0];
    evt.high_bank   = pending_bank;
    evt.reg_address = pending_address;
    evt.reg_data    = stream_byte;

    if (finished) begin
      end_now = 1'b0;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (stream_byte == CMD_SYNC) begin
            evt.has_primary = 1'b1;
            evt.kind        = EV_WAIT;
            evt.sync_count  = COUNT_W'(1);
          end else if (stream_byte == CMD_SYNC_N) begin
            if (is_last) begin
              evt.has_primary = 1'b1;
              evt.kind        = EV_WAIT;
              evt.sync_count  = COUNT_W'(2);
            end else begin
              phase_next       = PH_COUNT;
              count_acc_next   = '0;
              count_shift_next = '0;
            end
          end else if (stream_byte == CMD_LOOP) begin
            if (regs.loop_enabled &&
                ({1'b0, passes_done} + 9'd1 < {1'b0, regs.loops_wanted})) begin
              passes_done_next = passes_done + 8'd1;
              evt.has_primary  = 1'b1;
              evt.kind         = EV_RESTART;
              end_now          = 1'b0;
            end else begin
              end_now = 1'b1;
            end
          end else if (!stream_byte[7] && !is_last) begin
            pending_device_next = stream_byte[6:1];
            pending_bank_next   = stream_byte[0];
            phase_next          = PH_ADDR;
          end
        end
        PH_ADDR: begin
          pending_address_next = stream_byte;
          phase_next           = PH_DATA;
        end
        PH_DATA: begin
          evt.has_primary = dev_ok;
          phase_next      = PH_IDLE;
        end
        PH_COUNT: begin
          if (!stream_byte[7] || (count_shift == 2'd3) || is_last) begin
            evt.has_primary  = 1'b1;
            evt.kind         = EV_WAIT;
            evt.sync_count   = {1'b0, acc_merged} + COUNT_W'(2);
            phase_next       = PH_IDLE;
            count_acc_next   = '0;
            count_shift_next = '0;
          end else begin
            count_acc_next   = acc_merged;
            count_shift_next = count_shift + 2'd1;
          end
        end
      endcase
    end

    // end of data: one trailing end event, then everything is ignored
    if (end_now) begin
      evt.has_end   = 1'b1;
      finished_next = 1'b1;
      phase_next    = PH_IDLE;
    end

    // write fields only travel with a write
    if (!(evt.has_primary && evt.kind == EV_WRITE)) begin
      evt.device      = '0;
      evt.high_bank   = 1'b0;
      evt.reg_address = '0;
      evt.reg_data    = '0;
    end

    evt_any = evt.has_primary || evt.has_end;
  end

endmodule

FILE: src/slcd_event_pipe.sv
// ----------------------------------------------------------------------------
// slcd_event_pipe
// Event register, wait multiply register and output sequencing that sends
// the primary event and the trailing end one after the other.
// ----------------------------------------------------------------------------
module slcd_event_pipe (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  slcd_pkg::slcd_event_t evt,
  input  logic [31:0]           sync_samples,
  output logic                  space,
  slcd_event_if.source          events
);
  import slcd_pkg::*;

  logic              s1_valid;
  slcd_event_t       s1_evt;
  logic              s2_valid;
  slcd_event_t       s2_evt;
  logic [PROD_W-1:0] s2_prod;
  logic              s2_primary_sent;

  logic              cur_primary;
  logic              cur_last;
  logic              s2_done;
  logic              s2_ready;
  logic [PROD_W-1:0] rounded;

  // which result is on the output now
  assign cur_primary = s2_evt.has_primary && !s2_primary_sent;
  assign cur_last    = !(cur_primary && s2_evt.has_end);
  assign s2_done     = events.valid && events.ready && cur_last;
  assign s2_ready    = !s2_valid || s2_done;
  assign space       = !s1_valid || s2_ready;

  // decoded event register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (space) begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (space) begin
      s1_evt <= evt;
    end
  end

  // multiply register: 16.16 sync length times sync count
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid        <= 1'b0;
      s2_primary_sent <= 1'b0;
    end else if (s2_ready) begin
      s2_valid        <= s1_valid;
      s2_primary_sent <= 1'b0;
    end else if (events.valid && events.ready) begin
      s2_primary_sent <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_evt  <= s1_evt;
      s2_prod <= PROD_W'(sync_samples) * PROD_W'(s1_evt.sync_count);
    end
  end

  // round half up and drop the fraction
  assign rounded = s2_prod + ROUND_HALF;

  // output mux
  always_comb begin
    events.valid       = s2_valid;
    events.last_of_run = cur_last;
    if (cur_primary) begin
      events.event_kind  = s2_evt.kind;
      events.device      = s2_evt.device;
      events.high_bank   = s2_evt.high_bank;
      events.reg_address = s2_evt.reg_address;
      events.reg_data    = s2_evt.reg_data;
      events.wait_samples = (s2_evt.kind == EV_WAIT) ?
                            rounded[FRAC_W +: WAIT_W] : '0;
    end else begin
      events.event_kind   = EV_END;
      events.device       = '0;
      events.high_bank    = 1'b0;
      events.reg_address  = '0;
      events.reg_data     = '0;
      events.wait_samples = '0;
    end
  end

endmodule

FILE: src/sound_log_command_decoder.sv
// ----------------------------------------------------------------------------
// sound_log_command_decoder
// Byte-wise decoder for a sound-chip register log dump section.
// ----------------------------------------------------------------------------
// Takes one dump byte per clock while there is space and emits register
// writes, waits in output samples, restart-at-loop-point and end events.
// A byte is parsed in the cycle it is taken; the event then passes through
// the event register and the product register behind the 32 x 29 bit wait
// multiplier. Bytes that yield one result sustain one byte per cycle
// while the output is ready; a byte that yields a result plus the end
// event holds the output until both are sent. Bytes that yield no result
// take no pipeline slot but are only taken while there is space. After
// the end event every byte is taken and dropped until reset.
module sound_log_command_decoder #(
  parameter int unsigned MAX_DEVICES = 8
) (
  input  logic         clk,
  input  logic         rst,
  slcd_stream_if.sink  stream,
  slcd_event_if.source events,
  slcd_cfg_if.sink     cfg
);
  import slcd_pkg::*;

  slcd_cfg_t   regs;
  slcd_event_t evt;
  logic        evt_any;
  logic        space;
  logic        take;

  assign stream.ready = space;
  assign take         = stream.valid && space;

  // configuration registers
  slcd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // command parser
  slcd_decoder #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_dec (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .stream_byte (stream.stream_byte),
    .is_last     (stream.is_last),
    .regs        (regs),
    .evt         (evt),
    .evt_any     (evt_any)
  );

  // wait multiply and output sequencing
  slcd_event_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .push         (take && evt_any),
    .evt          (evt),
    .sync_samples (regs.sync_samples),
    .space        (space),
    .events       (events)
  );

  // an end event always closes its run
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind == EV_END) |-> events.last_of_run)
    else $error("end event not marked last of run");

  // a result that is not last is followed by the end event
  a_end_follows: assert property (@(posedge clk) disable iff (rst)
    events.valid && events.ready && !events.last_of_run |=>
      events.valid && (events.event_kind == EV_END))
    else $error("missing end event after non-final result");

  // only waits carry a sample count
  a_wait_only: assert property (@(posedge clk) disable iff (rst)
    events.valid && (events.event_kind != EV_WAIT) |-> (events.wait_samples == '0))
    else $error("sample count on a non-wait event");

endmodule
